/* src/sfir_pkg.sv */
package sfir_pkg;

  localparam int WINDOW_LEN = 22;
  localparam int SAMPLE_W   = 24;
  localparam int NUM_COEFS  = 10;
  localparam int NUM_REGS   = NUM_COEFS / 2;
  localparam int COEF_W     = 24;
  localparam int CFG_W      = 2 * COEF_W;
  localparam int CFG_IDX_W  = 3;
  localparam int FRAC_BITS  = 22;
  localparam int OUT_W      = 26;
  localparam int CENTER     = 10;
  localparam int PAIR_W     = SAMPLE_W + 1;
  localparam int PROD_W     = PAIR_W + COEF_W;
  localparam int ACC_W      = PROD_W + 4;
  localparam int Q_W        = ACC_W - FRAC_BITS;

  typedef logic signed [SAMPLE_W-1:0] sample_t;
  typedef logic signed [COEF_W-1:0]   coef_t;
  typedef logic signed [PROD_W-1:0]   prod_t;
  typedef logic signed [ACC_W-1:0]    acc_t;

  typedef logic [WINDOW_LEN-1:0][SAMPLE_W-1:0] window_t;
  typedef logic [NUM_COEFS-1:0][COEF_W-1:0]    coef_arr_t;
  typedef logic [NUM_COEFS-1:0][PROD_W-1:0]    prod_arr_t;

  typedef struct packed {
    logic valid;
    logic last;
  } stage_ctl_t;

endpackage

/* src/sfir_mult.sv */
module sfir_mult
  import sfir_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  stage_ctl_t ctl_in,
  input  window_t    window,
  input  coef_arr_t  coefs,
  input  logic       down_ready,
  output logic       ready,
  output stage_ctl_t ctl,
  output prod_arr_t  prods,
  output sample_t    center
);

  prod_arr_t prods_next;

  assign ready = !ctl.valid || down_ready;

  // mirrored pairs (k, 21-k), each sum exact in one extra bit
  always_comb begin
    for (int k = 0; k < NUM_COEFS; k++) begin
      logic signed [PAIR_W-1:0] pair;
      prod_t                    prod;
      pair = PAIR_W'($signed(window[k])) + PAIR_W'($signed(window[WINDOW_LEN-1-k]));
      prod = PROD_W'(pair) * PROD_W'($signed(coefs[k]));
      prods_next[k] = prod;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl <= '0;
    end else if (ready) begin
      ctl <= ctl_in;
    end
    if (ready && ctl_in.valid) begin
      prods  <= prods_next;
      center <= $signed(window[CENTER]);
    end
  end

endmodule

/* src/sfir_sum.sv */
module sfir_sum
  import sfir_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst,
  input  stage_ctl_t               ctl_in,
  input  prod_arr_t                prods,
  input  sample_t                  center,
  output logic                     ready,
  output logic                     filtered_valid,
  input  logic                     filtered_ready,
  output logic signed [OUT_W-1:0]  filtered,
  output logic                     last_out
);

  stage_ctl_t ctl;
  acc_t       part0, part1, part2;
  acc_t       part0_next, part1_next, part2_next;
  logic       out_ready;
  logic signed [OUT_W-1:0] filtered_next;

  assign out_ready = !filtered_valid || filtered_ready;
  assign ready     = !ctl.valid || out_ready;

  // first level: three partial sums
  always_comb begin
    part0_next = ACC_W'($signed(prods[0])) + ACC_W'($signed(prods[1]))
               + ACC_W'($signed(prods[2])) + ACC_W'($signed(prods[3]));
    part1_next = ACC_W'($signed(prods[4])) + ACC_W'($signed(prods[5]))
               + ACC_W'($signed(prods[6])) + ACC_W'($signed(prods[7]));
    part2_next = ACC_W'($signed(prods[8])) + ACC_W'($signed(prods[9]))
               + (ACC_W'(center) <<< FRAC_BITS);
  end

  // final add, round half up, saturate
  always_comb begin
    acc_t total;
    acc_t rounded;
    logic signed [Q_W-1:0] q;
    total   = part0 + part1 + part2;
    rounded = total + (ACC_W'(1) <<< (FRAC_BITS - 1));
    q       = $signed(rounded[ACC_W-1:FRAC_BITS]);
    if (q[Q_W-1:OUT_W-1] == '0 || q[Q_W-1:OUT_W-1] == '1) begin
      filtered_next = q[OUT_W-1:0];
    end else if (q[Q_W-1]) begin
      filtered_next = {1'b1, {(OUT_W-1){1'b0}}};
    end else begin
      filtered_next = {1'b0, {(OUT_W-1){1'b1}}};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl            <= '0;
      filtered_valid <= 1'b0;
    end else begin
      if (ready) begin
        ctl <= ctl_in;
      end
      if (out_ready) begin
        filtered_valid <= ctl.valid;
      end
    end
    if (ready && ctl_in.valid) begin
      part0 <= part0_next;
      part1 <= part1_next;
      part2 <= part2_next;
    end
    if (out_ready && ctl.valid) begin
      filtered <= filtered_next;
      last_out <= ctl.last;
    end
  end

endmodule

/* src/symmetric_fir_highpass_21tap.sv */
// after its sample transfer, a result passes the window, product and partial-sum
// registers, then the rounded and saturated output register
// throughput: one sample per cycle while results are taken; each stage holds when full
// reset clears the delay line, the coefficient registers and all stage valids
module symmetric_fir_highpass_21tap
  import sfir_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    cfg_we,
  input  logic [CFG_IDX_W-1:0]    cfg_index,
  input  logic [CFG_W-1:0]        cfg_data,
  input  logic signed [SAMPLE_W-1:0] sample,
  input  logic                    last_in,
  input  logic                    sample_valid,
  output logic                    sample_ready,
  output logic signed [OUT_W-1:0] filtered,
  output logic                    last_out,
  output logic                    filtered_valid,
  input  logic                    filtered_ready
);

  logic [NUM_REGS-1:0][CFG_W-1:0] coef_regs;
  coef_arr_t  coefs;
  window_t    window;
  stage_ctl_t win_ctl;
  stage_ctl_t mult_ctl;
  logic       mult_ready;
  logic       sum_ready;
  prod_arr_t  prods;
  sample_t    center;
  logic       accept;

  assign sample_ready = !win_ctl.valid || mult_ready;
  assign accept       = sample_valid && sample_ready;

  always_comb begin
    for (int k = 0; k < NUM_COEFS; k++) begin
      coefs[k] = coef_regs[k/2][(k%2)*COEF_W +: COEF_W];
    end
  end

  // entry 21 takes the newest sample, entry 0 the oldest
  always_ff @(posedge clk) begin
    if (rst) begin
      coef_regs <= '0;
      window    <= '0;
      win_ctl   <= '0;
    end else begin
      if (cfg_we && cfg_index < CFG_IDX_W'(NUM_REGS)) begin
        coef_regs[cfg_index] <= cfg_data;
      end
      if (sample_ready) begin
        win_ctl.valid <= sample_valid;
        win_ctl.last  <= last_in;
      end
      if (accept) begin
        window <= {sample, window[WINDOW_LEN-1:1]};
      end
    end
  end

  sfir_mult u_mult (
    .clk        (clk),
    .rst        (rst),
    .ctl_in     (win_ctl),
    .window     (window),
    .coefs      (coefs),
    .down_ready (sum_ready),
    .ready      (mult_ready),
    .ctl        (mult_ctl),
    .prods      (prods),
    .center     (center)
  );

  sfir_sum u_sum (
    .clk            (clk),
    .rst            (rst),
    .ctl_in         (mult_ctl),
    .prods          (prods),
    .center         (center),
    .ready          (sum_ready),
    .filtered_valid (filtered_valid),
    .filtered_ready (filtered_ready),
    .filtered       (filtered),
    .last_out       (last_out)
  );

endmodule

/* test/tb_top.sv */
`timescale 1ns / 100ps

module tb_top
  import sfir_pkg::*;
;

  localparam int WATCHDOG_LIMIT = 1000;
  localparam int REPORT_MAX     = 10;
  localparam int PHASE_ITEMS    = 150;

  typedef enum logic [CFG_IDX_W-1:0] {
    COEF_PAIR_0, COEF_PAIR_1, COEF_PAIR_2, COEF_PAIR_3, COEF_PAIR_4
  } coef_reg_e;

  typedef enum int {COEF_ZERO, COEF_MAX, COEF_MIN, COEF_FULL, COEF_SMALL, COEF_MIXED} coef_mode_e;

  typedef struct {
    sample_t smp;
    logic    last;
  } sample_item_t;

  typedef struct {
    logic signed [OUT_W-1:0] value;
    logic                    last;
  } filt_result_t;

  logic                       clk;
  logic                       rst            = 1'b1;
  logic                       cfg_we         = 1'b0;
  logic [CFG_IDX_W-1:0]       cfg_index      = '0;
  logic [CFG_W-1:0]           cfg_data       = '0;
  logic signed [SAMPLE_W-1:0] sample         = '0;
  logic                       last_in        = 1'b0;
  logic                       sample_valid   = 1'b0;
  logic                       sample_ready;
  logic signed [OUT_W-1:0]    filtered;
  logic                       last_out;
  logic                       filtered_valid;
  logic                       filtered_ready = 1'b0;

  symmetric_fir_highpass_21tap dut (
    .clk            (clk),
    .rst            (rst),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .sample         (sample),
    .last_in        (last_in),
    .sample_valid   (sample_valid),
    .sample_ready   (sample_ready),
    .filtered       (filtered),
    .last_out       (last_out),
    .filtered_valid (filtered_valid),
    .filtered_ready (filtered_ready)
  );

  // own copy of the filter state and coefficients
  sample_t      tap_line [WINDOW_LEN];
  coef_t        coef_val [NUM_COEFS];

  sample_item_t sample_queue[$];
  filt_result_t expected_filtered[$];
  filt_result_t head_result;

  int   mismatches  = 0;
  int   idle_cycles = 0;
  int   tx_gap      = 0;
  int   rx_stall    = 0;
  bit   tx_quiet    = 0;
  bit   rx_quiet    = 0;
  logic in_fire     = 1'b0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 55) return 0;
    if (roll < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic sample_t rand_sample();
    case ($urandom_range(0, 9))
      0:       return {1'b0, {(SAMPLE_W-1){1'b1}}};
      1:       return {1'b1, {(SAMPLE_W-1){1'b0}}};
      2:       return sample_t'($urandom_range(0, 511)) - sample_t'(256);
      default: return sample_t'($urandom);
    endcase
  endfunction

  function automatic coef_t pick_coef(coef_mode_e mode);
    coef_mode_e m;
    m = mode;
    if (m == COEF_MIXED) m = coef_mode_e'($urandom_range(COEF_ZERO, COEF_FULL));
    case (m)
      COEF_ZERO:  return '0;
      COEF_MAX:   return {1'b0, {(COEF_W-1){1'b1}}};
      COEF_MIN:   return {1'b1, {(COEF_W-1){1'b0}}};
      COEF_SMALL: return coef_t'($urandom_range(0, 2**21 - 1)) - coef_t'(2**20);
      default:    return coef_t'($urandom);
    endcase
  endfunction

  // shift in one sample and work out the rounded, saturated output
  function automatic filt_result_t filter_step(sample_t s, logic lst);
    longint       acc;
    longint       y;
    filt_result_t r;
    for (int i = 0; i < WINDOW_LEN - 1; i++) tap_line[i] = tap_line[i+1];
    tap_line[WINDOW_LEN-1] = s;
    acc = longint'(tap_line[CENTER]) <<< FRAC_BITS;
    // mirrored pairs: k with 21-k, entry 11 left out
    for (int k = 0; k < NUM_COEFS; k++)
      acc += longint'(coef_val[k]) *
             (longint'(tap_line[k]) + longint'(tap_line[WINDOW_LEN-1-k]));
    y = (acc + (longint'(1) <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
    if (y > (longint'(1) <<< (OUT_W - 1)) - 1) y = (longint'(1) <<< (OUT_W - 1)) - 1;
    if (y < -(longint'(1) <<< (OUT_W - 1))) y = -(longint'(1) <<< (OUT_W - 1));
    r.value = y[OUT_W-1:0];
    r.last  = lst;
    return r;
  endfunction

  // sample driver
  always @(negedge clk) begin
    if (rst) begin
      sample_valid <= 1'b0;
    end else if (!sample_valid || in_fire) begin
      if (tx_gap > 0) begin
        sample_valid <= 1'b0;
        tx_gap--;
      end else if (sample_queue.size() != 0) begin
        sample_item_t it;
        it = sample_queue.pop_front();
        sample       <= it.smp;
        last_in      <= it.last;
        sample_valid <= 1'b1;
        if ($urandom_range(0, 49) == 0) tx_quiet = !tx_quiet;
        tx_gap = tx_quiet ? 0 : pick_gap();
      end else begin
        sample_valid <= 1'b0;
      end
    end
  end

  // result receiver back-pressure
  always @(negedge clk) begin
    if (rst) begin
      filtered_ready <= 1'b0;
    end else if (rx_stall > 0) begin
      filtered_ready <= 1'b0;
      rx_stall--;
    end else begin
      filtered_ready <= 1'b1;
      if ($urandom_range(0, 49) == 0) rx_quiet = !rx_quiet;
      rx_stall = rx_quiet ? 0 : pick_gap();
    end
  end

  // monitor: predict on sample transfer, check on result transfer
  always @(posedge clk) begin
    in_fire <= !rst && sample_valid && sample_ready;
    if (rst) begin
      idle_cycles = 0;
    end else begin
      if (filtered_valid && filtered_ready) begin
        if (expected_filtered.size() == 0) begin
          mismatches++;
          if (mismatches <= REPORT_MAX)
            $display("unexpected result: filtered=%0d last_out=%0b", filtered, last_out);
        end else begin
          head_result = expected_filtered.pop_front();
          if (filtered !== head_result.value || last_out !== head_result.last) begin
            mismatches++;
            if (mismatches <= REPORT_MAX)
              $display("mismatch: filtered exp %0d got %0d, last_out exp %0b got %0b",
                       head_result.value, filtered, head_result.last, last_out);
          end
        end
      end
      if (sample_valid && sample_ready)
        expected_filtered.push_back(filter_step(sample, last_in));
      if ((sample_valid && sample_ready) || (filtered_valid && filtered_ready) || cfg_we)
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("FAIL");
        $finish;
      end
    end
  end

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    if (idx < NUM_REGS) begin
      coef_val[2*idx]   = data[COEF_W-1:0];
      coef_val[2*idx+1] = data[CFG_W-1:COEF_W];
    end
  endtask

  task automatic load_coefs(coef_mode_e mode);
    for (int r = COEF_PAIR_0; r <= COEF_PAIR_4; r++)
      write_reg(CFG_IDX_W'(r), {pick_coef(mode), pick_coef(mode)});
    // writes to unmapped indexes must leave the coefficients alone
    if ($urandom_range(0, 1))
      write_reg(CFG_IDX_W'($urandom_range(NUM_REGS, 2**CFG_IDX_W - 1)),
                CFG_W'({$urandom, $urandom}));
    @(negedge clk) cfg_we <= 1'b0;
  endtask

  task automatic wait_drain();
    do @(posedge clk);
    while (sample_queue.size() != 0 || expected_filtered.size() != 0 || sample_valid);
    repeat (4) @(negedge clk);
  endtask

  task automatic push_sample(sample_t s, logic lst);
    sample_item_t it;
    it.smp  = s;
    it.last = lst;
    sample_queue.push_back(it);
  endtask

  initial begin
    coef_mode_e plan [7];
    sample_t    s_max;
    sample_t    s_min;
    plan  = '{COEF_FULL, COEF_SMALL, COEF_MIXED, COEF_MIN, COEF_ZERO, COEF_MAX, COEF_FULL};
    s_max = {1'b0, {(SAMPLE_W-1){1'b1}}};
    s_min = {1'b1, {(SAMPLE_W-1){1'b0}}};
    foreach (tap_line[i]) tap_line[i] = '0;
    foreach (coef_val[i]) coef_val[i] = '0;

    repeat (2) @(posedge clk);
    @(negedge clk) rst <= 1'b0;

    // start-up with reset coefficients: output is the centre tap alone
    push_sample(s_max, 1'b0);
    push_sample(s_min, 1'b1);
    push_sample('0, 1'b0);
    push_sample(sample_t'(-1), 1'b0);
    push_sample(sample_t'(1), 1'b1);
    push_sample(24'h555555, 1'b0);
    push_sample(24'hAAAAAA, 1'b0);
    for (int i = 0; i < 5; i++) push_sample(i[0] ? s_min : s_max, i == 4);
    wait_drain();

    // full-scale coefficients, drive into saturation both ways across a block end
    load_coefs(COEF_MAX);
    for (int i = 0; i < 12; i++) push_sample(i < 6 ? s_max : s_min, i == 5);
    wait_drain();

    foreach (plan[p]) begin
      load_coefs(plan[p]);
      for (int i = 0; i < PHASE_ITEMS; i++)
        push_sample(rand_sample(), $urandom_range(0, 7) == 0);
      wait_drain();
    end

    repeat (8) @(posedge clk);
    if (mismatches == 0 && expected_filtered.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
